// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  `ASSERT_CLK(lbl, (ante) |=> (cons))

`endif

// ===== hdl/asvg_pkg.sv =====
// constants, tables and types for the steering vector generator
// no dependencies
package asvg_pkg;

  localparam int ELEMENTS_PER_ROW = 20;
  localparam int ROW_COUNT        = 5;
  localparam int ANGLE_BITS       = 16;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 33;
  localparam int Z_W          = 32;
  localparam int TURN_W       = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

  localparam int INV_W   = 24;
  localparam int ROW_W   = 3;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 5;
  localparam int Q15_W   = 16;
  localparam logic [INV_W-1:0] INV_WL_RESET = 24'd65536;

  typedef enum logic [1:0] {
    CFG_INV_WAVELENGTH = 2'd0,
    CFG_SUBARRAY_ROW   = 2'd1
  } cfg_index_e;

  typedef logic signed [CORDIC_W-1:0] cordic_t;

  function automatic logic signed [Z_W-1:0] cordic_atan(input int unsigned i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/asvg_if.sv =====
// stream interfaces: direction words in, weight words out
// depends on asvg_pkg
interface asvg_dir_if #(parameter int ANGLE_BITS = asvg_pkg::ANGLE_BITS);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] theta;
  logic [ANGLE_BITS-1:0] phi;
  modport source (output valid, theta, phi, input ready);
  modport sink   (input valid, theta, phi, output ready);
endinterface

interface asvg_wt_if;
  logic                                valid;
  logic                                ready;
  logic [asvg_pkg::IDX_W-1:0]          element_index;
  logic signed [asvg_pkg::Q15_W-1:0]   weight_real;
  logic signed [asvg_pkg::Q15_W-1:0]   weight_imag;
  logic                                last;
  modport source (output valid, element_index, weight_real, weight_imag, last, input ready);
  modport sink   (input valid, element_index, weight_real, weight_imag, last, output ready);
endinterface

// ===== hdl/asvg_cordic.sv =====
// pipelined rotation cordic: turn angle to cos and sin in q30
// depends on asvg_pkg
module asvg_cordic #(
  parameter int TAG_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [asvg_pkg::TURN_W-1:0]       angle_i,
  input  logic [TAG_W-1:0]                  tag_i,
  output logic                              valid_o,
  output asvg_pkg::cordic_t                 cos_o,
  output asvg_pkg::cordic_t                 sin_o,
  output logic [TAG_W-1:0]                  tag_o
);
  localparam int N = asvg_pkg::CORDIC_STEPS;

  logic                             v_q   [0:N];
  asvg_pkg::cordic_t                x_q   [0:N];
  asvg_pkg::cordic_t                y_q   [0:N];
  logic signed [asvg_pkg::Z_W-1:0]  z_q   [0:N];
  logic [1:0]                       quad_q[0:N];
  logic [TAG_W-1:0]                 tag_q [0:N];

  logic              out_v_q;
  asvg_pkg::cordic_t cos_q, sin_q;
  logic [TAG_W-1:0]  out_tag_q;

  // load stage: quadrant split
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= asvg_pkg::CORDIC_X0;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({2'b00, angle_i[29:0]});
      quad_q[0] <= angle_i[31:30];
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    asvg_pkg::cordic_t dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - asvg_pkg::cordic_atan(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + asvg_pkg::cordic_atan(i);
        end
        quad_q[i+1] <= quad_q[i];
        tag_q[i+1]  <= tag_q[i];
      end
    end
  end

  // quadrant rotation back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[N])
        2'd0: begin
          cos_q <= x_q[N];
          sin_q <= y_q[N];
        end
        2'd1: begin
          cos_q <= -y_q[N];
          sin_q <= x_q[N];
        end
        2'd2: begin
          cos_q <= -x_q[N];
          sin_q <= -y_q[N];
        end
        default: begin
          cos_q <= y_q[N];
          sin_q <= -x_q[N];
        end
      endcase
      out_tag_q <= tag_q[N];
    end
  end

  assign valid_o = out_v_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign tag_o   = out_tag_q;
endmodule

// ===== hdl/array_steering_vector_generator_core.sv =====
// top level of the phased array steering vector generator
// depends on asvg_pkg, asvg_if and asvg_cordic
//
// One direction word (theta, phi in turn fractions) produces ELEMENTS_PER_ROW
// weight words, element 0 first, last set on the final one. Each weight is
// cos and sin of inv_wavelength * c * sin(theta) * (cos(phi) + sin(phi)) with
// c = row * ELEMENTS_PER_ROW + index, in signed q1.15 scaled by 32767. With
// the output always ready the element sequencer issues one element a cycle
// into the weight pipeline and takes the next direction as it issues the last
// element. Directions queue in the front pipeline (two cordics, 18 stages,
// then three multiply stages) while the sequencer is busy. A stall on the
// output freezes the whole weight path; nothing is dropped or repeated. A row
// setting at or above ROW_COUNT uses the last row. Registers are to be written
// only while the block is idle; the block itself does not enforce this.
module array_steering_vector_generator_core #(
  parameter int ELEMENTS_PER_ROW = asvg_pkg::ELEMENTS_PER_ROW,
  parameter int ROW_COUNT        = asvg_pkg::ROW_COUNT,
  parameter int ANGLE_BITS       = asvg_pkg::ANGLE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [asvg_pkg::CFG_W-1:0]   cfg_data_i,
  asvg_dir_if.sink                     dir_i,
  asvg_wt_if.source                    wt_o
);
  localparam int E_W     = (ELEMENTS_PER_ROW > 1) ? $clog2(ELEMENTS_PER_ROW) : 1;
  localparam int COORD_W = (ROW_COUNT * ELEMENTS_PER_ROW > 1) ?
                           $clog2(ROW_COUNT * ELEMENTS_PER_ROW) : 1;
  localparam int TAG_W   = asvg_pkg::IDX_W + 1;
  localparam int CW      = asvg_pkg::CORDIC_W;

  // configuration registers
  logic [asvg_pkg::INV_W-1:0] inv_q;
  logic [asvg_pkg::ROW_W-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= asvg_pkg::INV_WL_RESET;
      row_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        asvg_pkg::CFG_INV_WAVELENGTH: inv_q <= cfg_data_i[asvg_pkg::INV_W-1:0];
        asvg_pkg::CFG_SUBARRAY_ROW:   row_q <= cfg_data_i[asvg_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // element sequencer state
  logic [E_W-1:0]     e_q;
  logic [COORD_W-1:0] coord_q, coord_base;
  asvg_pkg::cordic_t  u_q;
  int                 row_eff;

  // pipeline advance controls
  logic adv, front_adv, seq_take, e_last;
  logic fu_v_q, busy_q;
  logic out_v_q;

  assign adv       = !out_v_q || wt_o.ready;
  assign e_last    = (e_q == E_W'(ELEMENTS_PER_ROW - 1));
  assign seq_take  = adv && (!busy_q || e_last);
  assign front_adv = !fu_v_q || seq_take;
  assign dir_i.ready = front_adv;

  // front: sin/cos of both angles
  logic [asvg_pkg::TURN_W-1:0] theta_turn, phi_turn;
  assign theta_turn = {dir_i.theta, (asvg_pkg::TURN_W - ANGLE_BITS)'(0)};
  assign phi_turn   = {dir_i.phi,   (asvg_pkg::TURN_W - ANGLE_BITS)'(0)};

  logic              th_v, ph_v;
  asvg_pkg::cordic_t th_cos, th_sin, ph_cos, ph_sin;
  logic              th_tag, ph_tag;

  asvg_cordic #(.TAG_W(1)) u_cordic_theta (
    .clk_i, .rst_ni, .en_i(front_adv), .valid_i(dir_i.valid && front_adv),
    .angle_i(theta_turn), .tag_i(1'b0), .valid_o(th_v),
    .cos_o(th_cos), .sin_o(th_sin), .tag_o(th_tag)
  );

  asvg_cordic #(.TAG_W(1)) u_cordic_phi (
    .clk_i, .rst_ni, .en_i(front_adv), .valid_i(dir_i.valid && front_adv),
    .angle_i(phi_turn), .tag_i(1'b0), .valid_o(ph_v),
    .cos_o(ph_cos), .sin_o(ph_sin), .tag_o(ph_tag)
  );

  // m1: cos(phi)+sin(phi); m2: split product; m3: recombine and scale to q30
  logic                 m1_v_q, m2_v_q;
  asvg_pkg::cordic_t    m1_st_q;
  logic signed [CW:0]   m1_sum_q;
  logic signed [CW+17:0] m2_lo_q;
  logic signed [CW+16:0] m2_hi_q;
  logic signed [CW+33:0] m3_full;
  asvg_pkg::cordic_t    fu_q;

  assign m3_full = (67'(m2_hi_q) <<< 17) + 67'(m2_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      fu_v_q <= 1'b0;
    end else if (front_adv) begin
      m1_v_q <= th_v && ph_v;
      m2_v_q <= m1_v_q;
      fu_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_adv) begin
      m1_st_q  <= th_sin;
      m1_sum_q <= (CW+1)'(ph_cos) + (CW+1)'(ph_sin);
      m2_lo_q  <= (CW+18)'(m1_st_q) * (CW+18)'($signed({1'b0, m1_sum_q[16:0]}));
      m2_hi_q  <= (CW+17)'(m1_st_q) * (CW+17)'($signed(m1_sum_q[CW:17]));
      fu_q     <= m3_full[62:30];
    end
  end

  // element sequencer
  always_comb begin
    row_eff = (int'(row_q) >= ROW_COUNT) ? ROW_COUNT - 1 : int'(row_q);
    coord_base = COORD_W'(row_eff * ELEMENTS_PER_ROW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      e_q     <= '0;
      coord_q <= '0;
    end else if (seq_take) begin
      busy_q  <= fu_v_q;
      e_q     <= '0;
      coord_q <= coord_base;
    end else if (adv) begin
      e_q     <= e_q + 1'b1;
      coord_q <= coord_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_take && fu_v_q) begin
      u_q <= fu_q;
    end
  end

  // weight path: e1 u*c, e2 split times inv_wavelength, e3 phase
  logic [E_W+4:0]      idx_wide;
  assign idx_wide = {5'b0, e_q};

  logic                e1_v_q, e2_v_q, e3_v_q;
  logic signed [45:0]  e1_uc_q;
  logic [TAG_W-1:0]    e1_tag_q, e2_tag_q, e3_tag_q;
  logic [46:0]         e2_lo_q, e2_hi_full;
  logic [22:0]         e2_hi_q;
  logic [45:0]         e3_prod;
  logic [31:0]         e3_phase_q;

  assign e2_hi_full = 47'(e1_uc_q[45:23]) * 47'(inv_q);
  assign e3_prod    = e2_lo_q[45:0] + {e2_hi_q, 23'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
    end else if (adv) begin
      e1_v_q <= busy_q;
      e2_v_q <= e1_v_q;
      e3_v_q <= e2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_uc_q    <= 46'(u_q) * 46'($signed({1'b0, coord_q}));
      e1_tag_q   <= {e_last, idx_wide[4:0]};
      e2_lo_q    <= 47'(e1_uc_q[22:0]) * 47'(inv_q);
      e2_hi_q    <= e2_hi_full[22:0];
      e2_tag_q   <= e1_tag_q;
      e3_phase_q <= e3_prod[45:14];
      e3_tag_q   <= e2_tag_q;
    end
  end

  // weight cordic
  logic              wc_v;
  asvg_pkg::cordic_t wc_cos, wc_sin;
  logic [TAG_W-1:0]  wc_tag;

  asvg_cordic #(.TAG_W(TAG_W)) u_cordic_weight (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e3_v_q),
    .angle_i(e3_phase_q), .tag_i(e3_tag_q), .valid_o(wc_v),
    .cos_o(wc_cos), .sin_o(wc_sin), .tag_o(wc_tag)
  );

  // q15 scaling: (v*32767 + 2^29) >> 30, then saturate
  logic signed [48:0] sc_re, sc_im;
  logic signed [18:0] q_re_q, q_im_q;
  logic               q_v_q;
  logic [TAG_W-1:0]   q_tag_q;

  assign sc_re = (49'(wc_cos) <<< 15) - 49'(wc_cos) + 49'sd536870912;
  assign sc_im = (49'(wc_sin) <<< 15) - 49'(wc_sin) + 49'sd536870912;

  function automatic logic signed [15:0] sat15(input logic signed [18:0] r);
    logic signed [15:0] s;
    if (r > 19'sd32767) begin
      s = 16'sd32767;
    end else if (r < -19'sd32767) begin
      s = -16'sd32767;
    end else begin
      s = r[15:0];
    end
    return s;
  endfunction

  logic signed [15:0] out_re_q, out_im_q;
  logic [TAG_W-1:0]   out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      q_v_q   <= wc_v;
      out_v_q <= q_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_re_q    <= sc_re[48:30];
      q_im_q    <= sc_im[48:30];
      q_tag_q   <= wc_tag;
      out_re_q  <= sat15(q_re_q);
      out_im_q  <= sat15(q_im_q);
      out_tag_q <= q_tag_q;
    end
  end

  assign wt_o.valid         = out_v_q;
  assign wt_o.element_index = out_tag_q[4:0];
  assign wt_o.last          = out_tag_q[5];
  assign wt_o.weight_real   = out_re_q;
  assign wt_o.weight_imag   = out_im_q;
endmodule

// ===== hdl/asvg_checker.sv =====
// port-level checks on the weight output of the generator
// depends on assert_macros.svh and asvg_pkg
`include "assert_macros.svh"

module asvg_checker #(
  parameter int ELEMENTS_PER_ROW = asvg_pkg::ELEMENTS_PER_ROW
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               valid_i,
  input logic                               ready_i,
  input logic [asvg_pkg::IDX_W-1:0]         index_i,
  input logic signed [asvg_pkg::Q15_W-1:0]  real_i,
  input logic signed [asvg_pkg::Q15_W-1:0]  imag_i,
  input logic                               last_i
);
  localparam logic [asvg_pkg::IDX_W-1:0] LAST_IDX =
    asvg_pkg::IDX_W'(ELEMENTS_PER_ROW - 1);

  // stalled word holds valid, index and real part
  `ASSERT_NEXT(a_hold, valid_i && !ready_i, valid_i && $stable(index_i) && $stable(real_i))
  // last mark only on the final element
  `ASSERT_CLK(a_last_idx, valid_i && last_i |-> index_i == LAST_IDX)
  // saturation never yields the most negative code
  `ASSERT_CLK(a_sat, valid_i |-> real_i != -16'sd32768 && imag_i != -16'sd32768)
endmodule

bind array_steering_vector_generator_core asvg_checker #(
  .ELEMENTS_PER_ROW(ELEMENTS_PER_ROW)
) u_asvg_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (wt_o.valid),
  .ready_i (wt_o.ready),
  .index_i (wt_o.element_index),
  .real_i  (wt_o.weight_real),
  .imag_i  (wt_o.weight_imag),
  .last_i  (wt_o.last)
);
